FILE: src/ec_key_hysteresis_scanner_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key hysteresis scanner
// Shared implication checks, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef EC_KEY_HYSTERESIS_SCANNER_CORE_DEFINES_SVH
`define EC_KEY_HYSTERESIS_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication.
`define EKHS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define EKHS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/ekhs_pkg.sv
// ----------------------------------------------------------------------------
// ekhs_pkg
// Shared widths, register codes, reset values and types of the key scanner.
// ----------------------------------------------------------------------------
package ekhs_pkg;

	localparam int ROW_W       = 2;
	localparam int COL_W       = 3;
	localparam int SAMPLE_BITS = 12;
	localparam int ROW_BITS_W  = 8;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;

	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 12;

	localparam logic [CFG_IDX_W-1:0] REG_PRESS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 1'd1;

	localparam logic [SAMPLE_BITS-1:0] PRESS_RESET   = 12'd2048;
	localparam logic [SAMPLE_BITS-1:0] RELEASE_RESET = 12'd1536;

	localparam int SENSE_ROWS_DEF = 4;
	localparam int KEY_COLS_DEF   = 8;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	// Running statistics of one key.
	typedef struct packed {
		sample_t min_v;
		sample_t max_v;
	} key_stat_t;

	// Decision for one item.
	typedef struct packed {
		logic      now_down;
		logic      changed;
		key_stat_t stat;
	} key_upd_t;

endpackage

FILE: src/ekhs_decide.sv
// ----------------------------------------------------------------------------
// ekhs_decide
// Hysteresis compare and running min/max update for one key.
// ----------------------------------------------------------------------------
module ekhs_decide (
	input  ekhs_pkg::sample_t   smp,
	input  logic                was_down,
	input  ekhs_pkg::sample_t   press_thr,
	input  ekhs_pkg::sample_t   release_thr,
	input  ekhs_pkg::key_stat_t stat_old,
	output ekhs_pkg::key_upd_t  upd
);

	ekhs_pkg::sample_t thr;

	// A pressed key uses the lower release level.
	assign thr = was_down ? release_thr : press_thr;

	always_comb begin
		upd.now_down  = smp > thr;
		upd.changed   = (smp > thr) != was_down;
		upd.stat.min_v = (smp < stat_old.min_v) ? smp : stat_old.min_v;
		upd.stat.max_v = (smp > stat_old.max_v) ? smp : stat_old.max_v;
	end

endmodule

FILE: src/ekhs_store.sv
// ----------------------------------------------------------------------------
// ekhs_store
// Row bitmaps of pressed keys and per-key min/max registers.
// ----------------------------------------------------------------------------
module ekhs_store #(
	parameter int SENSE_ROWS = ekhs_pkg::SENSE_ROWS_DEF,
	parameter int KEY_COLS   = ekhs_pkg::KEY_COLS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [(((SENSE_ROWS < 4) ? SENSE_ROWS : 4) > 1 ?
		$clog2((SENSE_ROWS < 4) ? SENSE_ROWS : 4) : 1)-1:0] row,
	input  logic [(((KEY_COLS < 8) ? KEY_COLS : 8) > 1 ?
		$clog2((KEY_COLS < 8) ? KEY_COLS : 8) : 1)-1:0] col,
	input  ekhs_pkg::key_upd_t  upd,
	output logic                was_down,
	output ekhs_pkg::key_stat_t stat_old,
	output logic [ekhs_pkg::ROW_BITS_W-1:0] row_after
);

	localparam int ROWS_USED = (SENSE_ROWS < 4) ? SENSE_ROWS : 4;
	localparam int COLS_USED = (KEY_COLS < 8) ? KEY_COLS : 8;
	localparam int NKEYS     = ROWS_USED * COLS_USED;
	localparam int KIW       = (NKEYS > 1) ? $clog2(NKEYS) : 1;

	logic [COLS_USED-1:0]    pressed_q [ROWS_USED];
	ekhs_pkg::sample_t       min_q     [NKEYS];
	ekhs_pkg::sample_t       max_q     [NKEYS];
	logic [KIW-1:0]          key_idx;
	logic [COLS_USED-1:0]    row_before;
	logic [COLS_USED-1:0]    row_new;

	assign key_idx    = KIW'(int'(row) * COLS_USED + int'(col));
	assign row_before = pressed_q[row];
	assign was_down   = row_before[col];
	assign stat_old.min_v = min_q[key_idx];
	assign stat_old.max_v = max_q[key_idx];

	always_comb begin
		row_new      = row_before;
		row_new[col] = upd.now_down;
	end

	assign row_after = ekhs_pkg::ROW_BITS_W'(row_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS_USED; i++) begin
				pressed_q[i] <= '0;
			end
			for (int k = 0; k < NKEYS; k++) begin
				min_q[k] <= '1;
				max_q[k] <= '0;
			end
		end else if (wr_en) begin
			pressed_q[row] <= row_new;
			min_q[key_idx] <= upd.stat.min_v;
			max_q[key_idx] <= upd.stat.max_v;
		end
	end

endmodule

FILE: src/ec_key_hysteresis_scanner_core.sv
// ----------------------------------------------------------------------------
// ec_key_hysteresis_scanner_core
// Per-key press/release hysteresis detector for a capacitive key matrix.
// Items pass the input register and the result register; an output stall holds both.
// Throughput: 1 item per cycle; the row bitmap and min/max registers are
// read and rewritten in the same cycle, so back-to-back items see fresh state.
// Reset: arst_n clears the pipeline, all pressed bits and max values to zero,
// min values to all ones, and thresholds to 2048 (press) and 1536 (release).
// ----------------------------------------------------------------------------
`include "ec_key_hysteresis_scanner_core_defines.svh"

module ec_key_hysteresis_scanner_core #(
	parameter int SENSE_ROWS = ekhs_pkg::SENSE_ROWS_DEF,
	parameter int KEY_COLS   = ekhs_pkg::KEY_COLS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [ekhs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ekhs_pkg::CFG_DATA_W-1:0]      cfg_data,
	// sample stream in
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [1:0] row_index, [4:2] col_index, [16:5] sample, [23:17] zero
	input  logic [ekhs_pkg::IN_TDATA_W-1:0]      s_tdata,
	// result stream out
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] key_pressed, [1] state_changed, [9:2] row_bits, [21:10] sample_min,
	// [33:22] sample_max, [39:34] zero
	output logic [ekhs_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	// Only rows 0..3 and columns 0..7 can be addressed; wrapped indices
	// stay below these counts.
	localparam int ROWS_USED = (SENSE_ROWS < 4) ? SENSE_ROWS : 4;
	localparam int COLS_USED = (KEY_COLS < 8) ? KEY_COLS : 8;
	localparam int RIW       = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;
	localparam int CIW       = (COLS_USED > 1) ? $clog2(COLS_USED) : 1;
	localparam int PAD_W     = ekhs_pkg::OUT_TDATA_W - 2 - ekhs_pkg::ROW_BITS_W
		- 2 * ekhs_pkg::SAMPLE_BITS;

	// Threshold registers.
	ekhs_pkg::sample_t press_thr_q;
	ekhs_pkg::sample_t release_thr_q;

	// Input stage.
	logic                            valid_s1;
	logic [ekhs_pkg::ROW_W-1:0]      row_s1;
	logic [ekhs_pkg::COL_W-1:0]      col_s1;
	ekhs_pkg::sample_t               sample_s1;

	// Result stage.
	logic                            valid_s2;
	logic                            key_pressed_s2;
	logic                            changed_s2;
	logic [ekhs_pkg::ROW_BITS_W-1:0] row_bits_s2;
	ekhs_pkg::sample_t               min_s2;
	ekhs_pkg::sample_t               max_s2;

	logic                            out_free;
	logic                            advance;
	logic                            accept;

	logic [RIW-1:0]                  row_map [4];
	logic [CIW-1:0]                  col_map [8];
	logic [RIW-1:0]                  row_w;
	logic [CIW-1:0]                  col_w;

	logic                            was_down;
	ekhs_pkg::key_stat_t             stat_old;
	ekhs_pkg::key_upd_t              upd;
	logic [ekhs_pkg::ROW_BITS_W-1:0] row_after;

	// ------------------------------------------------------------------
	// Handshake: the result register frees the input stage whenever it is
	// empty or being drained, so a new item enters every cycle unless stalled.
	// ------------------------------------------------------------------
	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Configuration: write thresholds; unknown indices are dropped.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_thr_q   <= ekhs_pkg::PRESS_RESET;
			release_thr_q <= ekhs_pkg::RELEASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ekhs_pkg::REG_PRESS: begin
					press_thr_q <= ekhs_pkg::SAMPLE_BITS'(cfg_data);
				end
				ekhs_pkg::REG_RELEASE: begin
					release_thr_q <= ekhs_pkg::SAMPLE_BITS'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input register: capture the item, hold it while the output stalls.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1    <= s_tdata[1:0];
			col_s1    <= s_tdata[4:2];
			sample_s1 <= s_tdata[16:5];
		end
	end

	// ------------------------------------------------------------------
	// Wrap row and column into the configured matrix size. The tables are
	// constants worked out at elaboration.
	// ------------------------------------------------------------------
	for (genvar g = 0; g < 4; g++) begin : g_row_map
		assign row_map[g] = RIW'(g % SENSE_ROWS);
	end
	for (genvar g = 0; g < 8; g++) begin : g_col_map
		assign col_map[g] = CIW'(g % KEY_COLS);
	end

	assign row_w = row_map[row_s1];
	assign col_w = col_map[col_s1];

	// ------------------------------------------------------------------
	// Key state: read the prior bit and stats, write back on advance.
	// ------------------------------------------------------------------
	ekhs_store #(
		.SENSE_ROWS (SENSE_ROWS),
		.KEY_COLS   (KEY_COLS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (advance),
		.row       (row_w),
		.col       (col_w),
		.upd       (upd),
		.was_down  (was_down),
		.stat_old  (stat_old),
		.row_after (row_after)
	);

	ekhs_decide u_decide (
		.smp         (sample_s1),
		.was_down    (was_down),
		.press_thr   (press_thr_q),
		.release_thr (release_thr_q),
		.stat_old    (stat_old),
		.upd         (upd)
	);

	// ------------------------------------------------------------------
	// Result register: load on advance, drop once taken.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_pressed_s2 <= upd.now_down;
			changed_s2     <= upd.changed;
			row_bits_s2    <= row_after;
			min_s2         <= upd.stat.min_v;
			max_s2         <= upd.stat.max_v;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{PAD_W{1'b0}}, max_s2, min_s2, row_bits_s2, changed_s2,
		key_pressed_s2};

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`EKHS_ASSERT_IMP(a_min_le_max, valid_s2, min_s2 <= max_s2,
		"result minimum above maximum")
	`EKHS_ASSERT_NXT(a_adv_loads_out, advance, valid_s2,
		"advanced item missing from result stage")
	`EKHS_ASSERT_IMP(a_stall_cause, !s_tready, valid_s1 && valid_s2 && !m_tready,
		"input stalled without a full pipeline")

endmodule
